### rtl/ect_pkg.sv
package ect_pkg;

   // Input item: one executed instruction address.
   typedef struct packed {
      logic [7:0]  exec_bank;
      logic [15:0] exec_pc;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [1:0]  region;
      logic        first_visit;
      logic [31:0] total_executed;
      logic [16:0] unique_wram;
      logic [19:0] unique_rom;
      logic [31:0] bank_executed;
      logic [15:0] bank_unique;
   } rsp_type;

   // Region codes.
   localparam logic [1:0] REGION_NONE = 2'd0;
   localparam logic [1:0] REGION_WRAM = 2'd1;
   localparam logic [1:0] REGION_ROM  = 2'd2;

   // Register index of the enable bit.
   localparam int CSR_ENABLE = 0;

   localparam logic [7:0] WRAM_BANK   = 8'h7E;
   localparam logic [6:0] MIRROR_MASK = 7'h7F;

   // Seen maps are stored as 32-bit rows.
   localparam int MAP_ROW_BITS = 32;
   localparam int WRAM_ROWS    = 65536 / MAP_ROW_BITS;
   localparam int BANK_ROWS    = 32768 / MAP_ROW_BITS;

   localparam int UNIQ_BITS = 16;

   localparam int ROM_BANKS_DEFAULT  = 16;
   localparam int COUNT_BITS_DEFAULT = 32;

endpackage

### rtl/execution_coverage_tracker.sv
// An accepted item is held in the stage 1 registers and then in the result register, which drives its result strobe.
// Throughput: one item per cycle while busy is low; rows hit back to back are forwarded, never stalled.
// Reset (synchronous): counters and enable clear at once, then a clearing pass zeroes
// every row of the seen-map memory and the per-bank counters, one row a cycle;
// busy stays high during that pass. Results cannot be stalled by the receiver.
module execution_coverage_tracker #(
   parameter int ROM_BANKS  = ect_pkg::ROM_BANKS_DEFAULT,
   parameter int COUNT_BITS = ect_pkg::COUNT_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   // item input
   input  logic             start,
   output logic             busy,
   input  ect_pkg::req_type req_data,
   // result output
   output logic             rsp_valid,
   output ect_pkg::rsp_type rsp_data,
   // configuration
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [1:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   // Seen-map memory layout: ROM rows first (bank * 1024 + pc[14:5]),
   // then the work RAM rows (pc[15:5]). Bit within a row is pc[4:0].
   localparam int WRAM_BASE = ROM_BANKS * ect_pkg::BANK_ROWS;
   localparam int MAP_ROWS  = WRAM_BASE + ect_pkg::WRAM_ROWS;
   localparam int MAP_AW    = $clog2(MAP_ROWS);
   localparam int BANK_AW   = (ROM_BANKS > 1) ? $clog2(ROM_BANKS) : 1;
   localparam int ROW_W     = ect_pkg::MAP_ROW_BITS;
   localparam int UNIQ_W    = ect_pkg::UNIQ_BITS;
   localparam int BANK_W    = COUNT_BITS + UNIQ_W;

   // ------------------------------------------------------------------
   // Configuration register
   // ------------------------------------------------------------------
   logic enable_ff, enable_in;
   logic csr_wr;

   // only one register exists, so every address decodes to it
   assign csr_wr    = psel && penable && pwrite && pready;
   assign enable_in = csr_wr ? pwdata[ect_pkg::CSR_ENABLE] : enable_ff;
   assign prdata    = (paddr[1:0] == 2'b00) ? 32'(enable_ff) : 32'(enable_ff);
   assign pready    = 1'b1;

   // ------------------------------------------------------------------
   // Clearing pass after reset
   // ------------------------------------------------------------------
   logic              clear_active_ff, clear_active_in;
   logic [MAP_AW-1:0] clr_cnt_ff, clr_cnt_in;

   always_comb begin
      clear_active_in = clear_active_ff;
      clr_cnt_in      = clr_cnt_ff;
      if (clear_active_ff) begin
         clr_cnt_in = clr_cnt_ff + MAP_AW'(1);
         if (clr_cnt_ff == MAP_AW'(MAP_ROWS - 1)) begin
            clear_active_in = 1'b0;
         end
      end
   end

   assign busy = clear_active_ff;

   logic accept;
   assign accept = start && !busy;

   // ------------------------------------------------------------------
   // Stage 0: decode the address and issue the memory reads
   // ------------------------------------------------------------------
   logic [6:0]         req_rom_bank;
   logic [BANK_AW-1:0] req_bank_idx;
   logic               req_is_wram;
   logic               req_is_rom;
   logic [1:0]         req_region;
   logic [MAP_AW-1:0]  req_row;

   always_comb begin
      req_rom_bank = req_data.exec_bank[6:0] & ect_pkg::MIRROR_MASK;
      req_bank_idx = req_rom_bank[BANK_AW-1:0];
      req_is_wram  = (req_data.exec_bank == ect_pkg::WRAM_BANK);
      req_is_rom   = !req_is_wram && (8'(req_rom_bank) < 8'(ROM_BANKS))
                     && req_data.exec_pc[15];
      if (req_is_wram) begin
         req_region = ect_pkg::REGION_WRAM;
         req_row    = MAP_AW'(WRAM_BASE) + MAP_AW'(req_data.exec_pc[15:5]);
      end else if (req_is_rom) begin
         req_region = ect_pkg::REGION_ROM;
         req_row    = MAP_AW'({req_bank_idx, req_data.exec_pc[14:5]});
      end else begin
         req_region = ect_pkg::REGION_NONE;
         req_row    = MAP_AW'({req_bank_idx, req_data.exec_pc[14:5]});
      end
   end

   // stage 1 item registers
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_enable_ff;
   logic [1:0]         s1_region_ff;
   logic [MAP_AW-1:0]  s1_row_ff;
   logic [4:0]         s1_bit_ff;
   logic [BANK_AW-1:0] s1_bank_ff;

   assign s1_valid_in = accept;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_enable_ff <= enable_ff;
         s1_region_ff <= req_region;
         s1_row_ff    <= req_row;
         s1_bit_ff    <= req_data.exec_pc[4:0];
         s1_bank_ff   <= req_bank_idx;
      end
   end

   // ------------------------------------------------------------------
   // Memories: seen map rows and per-bank counters
   // ------------------------------------------------------------------
   logic [ROW_W-1:0]  map_mem [MAP_ROWS];
   logic [BANK_W-1:0] bank_mem [ROM_BANKS];
   logic [ROW_W-1:0]  map_rd_ff;
   logic [BANK_W-1:0] bank_rd_ff;

   logic              map_we;
   logic [ROW_W-1:0]  map_wdata;
   logic              bank_we;
   logic [BANK_W-1:0] bank_wdata;

   always_ff @(posedge clock) begin
      if (accept) begin
         map_rd_ff <= map_mem[req_row];
      end
      if (clear_active_ff) begin
         map_mem[clr_cnt_ff] <= '0;
      end else if (map_we) begin
         map_mem[s1_row_ff] <= map_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_is_rom) begin
         bank_rd_ff <= bank_mem[req_bank_idx];
      end
      if (clear_active_ff) begin
         if (clr_cnt_ff < MAP_AW'(ROM_BANKS)) begin
            bank_mem[clr_cnt_ff[BANK_AW-1:0]] <= '0;
         end
      end else if (bank_we) begin
         bank_mem[s1_bank_ff] <= bank_wdata;
      end
   end

   // Forwarding: a read issued in the cycle of a write returns the old row,
   // so the last written row and bank entry are kept for the next item.
   logic               fwd_map_valid_ff, fwd_map_valid_in;
   logic [MAP_AW-1:0]  fwd_map_row_ff;
   logic [ROW_W-1:0]   fwd_map_data_ff;
   logic               fwd_bank_valid_ff, fwd_bank_valid_in;
   logic [BANK_AW-1:0] fwd_bank_idx_ff;
   logic [BANK_W-1:0]  fwd_bank_data_ff;

   assign fwd_map_valid_in  = map_we;
   assign fwd_bank_valid_in = bank_we;

   always_ff @(posedge clock) begin
      if (map_we) begin
         fwd_map_row_ff  <= s1_row_ff;
         fwd_map_data_ff <= map_wdata;
      end
      if (bank_we) begin
         fwd_bank_idx_ff  <= s1_bank_ff;
         fwd_bank_data_ff <= bank_wdata;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: test and set, counter updates, result
   // ------------------------------------------------------------------
   logic [COUNT_BITS-1:0] executed_total_ff, executed_total_in;
   logic [16:0]           wram_unique_ff, wram_unique_in;
   logic [19:0]           rom_unique_ff, rom_unique_in;

   logic                  s1_track;
   logic                  s1_rom;
   logic [ROW_W-1:0]      map_row_cur;
   logic [BANK_W-1:0]     bank_cur;
   logic                  first;
   logic [COUNT_BITS-1:0] bank_exec_cur, bank_exec_in;
   logic [UNIQ_W-1:0]     bank_uniq_cur, bank_uniq_in;

   logic             rsp_valid_ff, rsp_valid_in;
   ect_pkg::rsp_type rsp_data_ff, rsp_data_in;

   always_comb begin
      s1_track = s1_enable_ff && (s1_region_ff != ect_pkg::REGION_NONE);
      s1_rom   = s1_enable_ff && (s1_region_ff == ect_pkg::REGION_ROM);

      if (fwd_map_valid_ff && (fwd_map_row_ff == s1_row_ff)) begin
         map_row_cur = fwd_map_data_ff;
      end else begin
         map_row_cur = map_rd_ff;
      end
      if (fwd_bank_valid_ff && (fwd_bank_idx_ff == s1_bank_ff)) begin
         bank_cur = fwd_bank_data_ff;
      end else begin
         bank_cur = bank_rd_ff;
      end

      first     = s1_track && !map_row_cur[s1_bit_ff];
      map_we    = s1_valid_ff && s1_track;
      map_wdata = map_row_cur | (ROW_W'(1) << s1_bit_ff);

      bank_exec_cur = bank_cur[BANK_W-1:UNIQ_W];
      bank_uniq_cur = bank_cur[UNIQ_W-1:0];
      bank_exec_in  = (bank_exec_cur == '1) ? bank_exec_cur
                                            : bank_exec_cur + COUNT_BITS'(1);
      bank_uniq_in  = (first && (bank_uniq_cur != '1)) ? bank_uniq_cur + UNIQ_W'(1)
                                                       : bank_uniq_cur;
      bank_we    = s1_valid_ff && s1_rom;
      bank_wdata = {bank_exec_in, bank_uniq_in};

      executed_total_in = executed_total_ff;
      wram_unique_in    = wram_unique_ff;
      rom_unique_in     = rom_unique_ff;
      if (s1_valid_ff && s1_enable_ff) begin
         if (executed_total_ff != '1) begin
            executed_total_in = executed_total_ff + COUNT_BITS'(1);
         end
         if (first && (s1_region_ff == ect_pkg::REGION_WRAM) && (wram_unique_ff != '1)) begin
            wram_unique_in = wram_unique_ff + 17'd1;
         end
         if (first && s1_rom && (rom_unique_ff != '1)) begin
            rom_unique_in = rom_unique_ff + 20'd1;
         end
      end

      rsp_valid_in               = s1_valid_ff;
      rsp_data_in.region         = s1_enable_ff ? s1_region_ff : ect_pkg::REGION_NONE;
      rsp_data_in.first_visit    = first;
      rsp_data_in.total_executed = 32'(executed_total_in);
      rsp_data_in.unique_wram    = wram_unique_in;
      rsp_data_in.unique_rom     = rom_unique_in;
      rsp_data_in.bank_executed  = s1_rom ? 32'(bank_exec_in) : 32'd0;
      rsp_data_in.bank_unique    = s1_rom ? bank_uniq_in : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff         <= 1'b0;
         clear_active_ff   <= 1'b1;
         clr_cnt_ff        <= '0;
         s1_valid_ff       <= 1'b0;
         fwd_map_valid_ff  <= 1'b0;
         fwd_bank_valid_ff <= 1'b0;
         executed_total_ff <= '0;
         wram_unique_ff    <= '0;
         rom_unique_ff     <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         enable_ff         <= enable_in;
         clear_active_ff   <= clear_active_in;
         clr_cnt_ff        <= clr_cnt_in;
         s1_valid_ff       <= s1_valid_in;
         fwd_map_valid_ff  <= fwd_map_valid_in;
         fwd_bank_valid_ff <= fwd_bank_valid_in;
         executed_total_ff <= executed_total_in;
         wram_unique_ff    <= wram_unique_in;
         rom_unique_ff     <= rom_unique_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // once the clearing pass is over, busy never returns without a reset
   assert property (@(posedge clock) disable iff (reset) !busy |=> !busy)
      else $error("busy rose outside reset");

   // every accepted item gives a result strobe after the stage 1 and result registers
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> ##1 rsp_valid)
      else $error("result strobe missing");

   // a first visit in ROM always leaves a nonzero bank unique count and a nonzero ROM unique count
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.first_visit && (rsp_data.region == ect_pkg::REGION_ROM))
      |-> (rsp_data.bank_unique != 16'd0) && (rsp_data.unique_rom != 20'd0))
      else $error("ROM first visit without unique count");

   // unique ROM count never falls between consecutive results
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(rsp_valid)) |-> (rsp_data.unique_rom >= $past(rsp_data.unique_rom)))
      else $error("unique ROM count decreased");
`endif

endmodule
